>>> hdl/assert_macros.svh
// Assertion macros used by the transaction core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define MRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset cycles included.
`define MRM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hdl/mrm_pkg.sv
package mrm_pkg;

    localparam int unsigned MAX_QUANTITY = 6;
    localparam int unsigned MAX_PAYLOAD  = 62;

    localparam logic [1:0] KIND_READ    = 2'd0;
    localparam logic [1:0] KIND_WRITE   = 2'd1;
    localparam logic [1:0] KIND_RXBYTE  = 2'd2;
    localparam logic [1:0] KIND_TIMEOUT = 2'd3;

    localparam logic [1:0] OK_TX      = 2'd0;
    localparam logic [1:0] OK_PAYLOAD = 2'd1;
    localparam logic [1:0] OK_STATUS  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ARG   = 3'd1;
    localparam logic [2:0] ST_TIMEOUT   = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_EXCEPTION = 3'd4;
    localparam logic [2:0] ST_TOO_LARGE = 3'd5;

    localparam logic [7:0] FN_READ_HOLDING = 8'h03;
    localparam logic [7:0] FN_READ_INPUT   = 8'h04;
    localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FN_EXC_FLAG     = 8'h80;

    localparam logic CFG_SLAVE_ADDRESS = 1'b0;
    localparam logic CFG_CAPACITY      = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_TX, S_RXB, S_REL, S_REL_OUT, S_STAT
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE, PH_RD_HDR, PH_WR_HDR, PH_EXC_CRC, PH_RD_BODY, PH_WR_TAIL
    } t_phase;

    // CRC-16/MODBUS, reflected polynomial, one byte.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hdl/mrm_in_if.sv
interface mrm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        use_input_regs;
    logic [15:0] reg_address;
    logic [15:0] quantity_or_value;
    logic [7:0]  rx_byte;

    modport source (output valid, kind, use_input_regs, reg_address, quantity_or_value,
                    rx_byte, input ready);
    modport sink (input valid, kind, use_input_regs, reg_address, quantity_or_value,
                  rx_byte, output ready);
endinterface

>>> hdl/mrm_out_if.sv
interface mrm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic [7:0] exception_code;
    logic [5:0] data_length;
    logic       last;

    modport source (output valid, out_kind, out_byte, status, exception_code, data_length,
                    last, input ready);
    modport sink (input valid, out_kind, out_byte, status, exception_code, data_length,
                  last, output ready);
endinterface

>>> hdl/modbus_rtu_master_transaction_core.sv
// Channel   Direction  Carries
// i_req     in         read/write request, received byte or timeout event
// o_rsp     out        transmit byte, checked payload byte or transaction status
//
// A request is accepted and then sends its eight frame bytes, one after another, paced
// by the output register. A received byte is first accepted and then checked. Payload
// release reads each byte through the payload RAM's read port, then sends it out.
// Reset is synchronous and active low; the payload RAM is not cleared, since every
// entry is written before it is read within a transaction. Both sides may stall freely.
`include "assert_macros.svh"

module modbus_rtu_master_transaction_core
    import mrm_pkg::*;
#(
    parameter int RX_BUFFER_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    mrm_in_if.sink     i_req,
    mrm_out_if.source  o_rsp
);
    localparam int AW = $clog2(RX_BUFFER_BYTES);

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_slave;
    logic [5:0]  r_cap;
    logic [7:0]  r_func, n_func;
    logic [31:0] r_words, n_words;
    logic [15:0] r_txcrc, n_txcrc;
    logic [2:0]  r_txi, n_txi;
    logic [15:0] r_crc, n_crc;
    logic [23:0] r_hdr, n_hdr;
    logic [6:0]  r_cnt, n_cnt;
    logic [5:0]  r_exp, n_exp;
    logic [7:0]  r_prev, n_prev;
    logic [31:0] r_tail, n_tail;
    logic [5:0]  r_ri, n_ri;
    logic [7:0]  r_rx, n_rx;
    logic [2:0]  r_st, n_st;
    logic [7:0]  r_exc, n_exc;
    logic [5:0]  r_len, n_len;

    logic        r_ov, n_ov;
    logic [1:0]  r_okind, n_okind;
    logic [7:0]  r_obyte, n_obyte;
    logic [2:0]  r_ost, n_ost;
    logic [7:0]  r_oexc, n_oexc;
    logic [5:0]  r_olen, n_olen;
    logic        r_olast, n_olast;

    logic        slot_free;
    logic        in_xfer;
    logic [23:0] hdr_next;
    logic [15:0] crc_rx;
    logic [5:0]  cap_eff;
    logic [7:0]  tx_byte;
    logic        ram_we, ram_re;
    logic [7:0]  ram_rdata;

    assign slot_free = !r_ov || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign in_xfer = i_req.valid && i_req.ready;
    assign hdr_next = {r_hdr[15:0], r_rx};
    assign crc_rx = crc16_update(r_crc, r_rx);
    assign cap_eff = (r_cap > 6'(MAX_PAYLOAD)) ? 6'(MAX_PAYLOAD) : r_cap;

    always_comb begin
        case (r_txi)
            3'd0:    tx_byte = r_slave;
            3'd1:    tx_byte = r_func;
            3'd2:    tx_byte = r_words[31:24];
            3'd3:    tx_byte = r_words[23:16];
            3'd4:    tx_byte = r_words[15:8];
            3'd5:    tx_byte = r_words[7:0];
            3'd6:    tx_byte = r_txcrc[7:0];
            default: tx_byte = r_txcrc[15:8];
        endcase
    end

    // The payload buffer: written while the body arrives, read back on release.
    assign ram_we = (r_state == S_RXB) && (r_phase == PH_RD_BODY) && (r_cnt < {1'b0, r_exp});
    assign ram_re = (r_state == S_REL) && (r_ri != r_exp);

    mrm_ram #(.WIDTH(8), .DEPTH(RX_BUFFER_BYTES)) u_payload (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(r_cnt)),
        .i_wdata (r_rx),
        .i_re    (ram_re),
        .i_raddr (AW'(r_ri)),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave <= 8'd254;
            r_cap   <= 6'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SLAVE_ADDRESS: r_slave <= i_cfg_data;
                CFG_CAPACITY:      r_cap   <= i_cfg_data[5:0];
                default:           r_cap   <= r_cap;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
            r_ov    <= 1'b0;
            r_func  <= 8'h00;
            r_words <= 32'h0;
            r_crc   <= 16'hFFFF;
            r_hdr   <= 24'h0;
            r_cnt   <= 7'd0;
            r_exp   <= 6'd0;
            r_txi   <= 3'd0;
            r_ri    <= 6'd0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_ov    <= n_ov;
            r_func  <= n_func;
            r_words <= n_words;
            r_crc   <= n_crc;
            r_hdr   <= n_hdr;
            r_cnt   <= n_cnt;
            r_exp   <= n_exp;
            r_txi   <= n_txi;
            r_ri    <= n_ri;
        end
        r_txcrc <= n_txcrc;
        r_prev  <= n_prev;
        r_tail  <= n_tail;
        r_rx    <= n_rx;
        r_st    <= n_st;
        r_exc   <= n_exc;
        r_len   <= n_len;
        r_okind <= n_okind;
        r_obyte <= n_obyte;
        r_ost   <= n_ost;
        r_oexc  <= n_oexc;
        r_olen  <= n_olen;
        r_olast <= n_olast;
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_func  = r_func;
        n_words = r_words;
        n_txcrc = r_txcrc;
        n_txi   = r_txi;
        n_crc   = r_crc;
        n_hdr   = r_hdr;
        n_cnt   = r_cnt;
        n_exp   = r_exp;
        n_prev  = r_prev;
        n_tail  = r_tail;
        n_ri    = r_ri;
        n_rx    = r_rx;
        n_st    = r_st;
        n_exc   = r_exc;
        n_len   = r_len;
        n_ov    = r_ov && !o_rsp.ready;
        n_okind = r_okind;
        n_obyte = r_obyte;
        n_ost   = r_ost;
        n_oexc  = r_oexc;
        n_olen  = r_olen;
        n_olast = r_olast;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_st  = ST_INVALID;
                    n_exc = 8'h00;
                    n_len = 6'd0;
                    case (i_req.kind)
                        KIND_READ, KIND_WRITE: begin
                            if (i_req.kind == KIND_READ && (i_req.quantity_or_value == 16'd0 ||
                                    i_req.quantity_or_value > 16'(MAX_QUANTITY))) begin
                                n_st    = ST_BAD_ARG;
                                n_phase = PH_IDLE;
                                n_state = S_STAT;
                            end else begin
                                n_func = (i_req.kind == KIND_WRITE) ? FN_WRITE_SINGLE :
                                         (i_req.use_input_regs ? FN_READ_INPUT : FN_READ_HOLDING);
                                n_words = {i_req.reg_address, i_req.quantity_or_value};
                                n_phase = (i_req.kind == KIND_WRITE) ? PH_WR_HDR : PH_RD_HDR;
                                n_crc   = 16'hFFFF;
                                n_hdr   = 24'h0;
                                n_cnt   = 7'd0;
                                n_exp   = 6'd0;
                                n_txcrc = 16'hFFFF;
                                n_txi   = 3'd0;
                                n_state = S_TX;
                            end
                        end
                        KIND_RXBYTE: begin
                            n_rx    = i_req.rx_byte;
                            n_state = S_RXB;
                        end
                        default: begin
                            if (r_phase != PH_IDLE) begin
                                n_st    = (r_phase == PH_EXC_CRC) ? ST_INVALID : ST_TIMEOUT;
                                n_phase = PH_IDLE;
                                n_state = S_STAT;
                            end
                        end
                    endcase
                end
            end
            S_TX: begin
                // Frame CRC is folded in as each of the first six bytes leaves.
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_okind = OK_TX;
                    n_obyte = tx_byte;
                    n_ost   = ST_OK;
                    n_oexc  = 8'h00;
                    n_olen  = 6'd0;
                    n_olast = (r_txi == 3'd7);
                    if (r_txi < 3'd6) begin
                        n_txcrc = crc16_update(r_txcrc, tx_byte);
                    end
                    n_txi = r_txi + 3'd1;
                    if (r_txi == 3'd7) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RXB: begin
                n_state = S_IDLE;
                case (r_phase)
                    PH_RD_HDR, PH_WR_HDR: begin
                        n_hdr = hdr_next;
                        n_crc = crc_rx;
                        n_cnt = r_cnt + 7'd1;
                        if (r_cnt >= 7'd2) begin
                            n_cnt = 7'd0;
                            if (hdr_next[23:16] != r_slave) begin
                                n_phase = PH_IDLE;
                                n_state = S_STAT;
                            end else if (hdr_next[15:8] == (r_func | FN_EXC_FLAG)) begin
                                n_phase = PH_EXC_CRC;
                            end else if (hdr_next[15:8] != r_func) begin
                                n_phase = PH_IDLE;
                                n_state = S_STAT;
                            end else if (r_phase == PH_WR_HDR) begin
                                n_phase = PH_WR_TAIL;
                            end else if (hdr_next[7:0] > {2'b00, cap_eff} ||
                                    10'(hdr_next[7:0]) + 10'd2 > 10'(RX_BUFFER_BYTES)) begin
                                n_st    = ST_TOO_LARGE;
                                n_phase = PH_IDLE;
                                n_state = S_STAT;
                            end else begin
                                n_exp   = hdr_next[5:0];
                                n_phase = PH_RD_BODY;
                            end
                        end
                    end
                    PH_EXC_CRC: begin
                        if (r_cnt == 7'd0) begin
                            n_prev = r_rx;
                            n_cnt  = 7'd1;
                        end else begin
                            if ({r_rx, r_prev} == r_crc) begin
                                n_st  = ST_EXCEPTION;
                                n_exc = r_hdr[7:0];
                            end
                            n_phase = PH_IDLE;
                            n_state = S_STAT;
                        end
                    end
                    PH_RD_BODY: begin
                        if (r_cnt < {1'b0, r_exp}) begin
                            n_crc = crc_rx;
                            n_cnt = r_cnt + 7'd1;
                        end else if (r_cnt == {1'b0, r_exp}) begin
                            n_prev = r_rx;
                            n_cnt  = r_cnt + 7'd1;
                        end else begin
                            n_phase = PH_IDLE;
                            if ({r_rx, r_prev} == r_crc) begin
                                n_ri    = 6'd0;
                                n_state = S_REL;
                            end else begin
                                n_state = S_STAT;
                            end
                        end
                    end
                    PH_WR_TAIL: begin
                        if (r_cnt < 7'd3) begin
                            n_crc = crc_rx;
                        end
                        if (r_cnt < 7'd4) begin
                            n_tail = {r_tail[23:0], r_rx};
                            n_cnt  = r_cnt + 7'd1;
                        end else begin
                            if ({r_rx, r_tail[7:0]} == r_crc &&
                                    {r_hdr[7:0], r_tail[31:8]} == r_words) begin
                                n_st = ST_OK;
                            end
                            n_phase = PH_IDLE;
                            n_state = S_STAT;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_REL: begin
                if (r_ri == r_exp) begin
                    n_st    = ST_OK;
                    n_len   = r_exp;
                    n_state = S_STAT;
                end else begin
                    n_state = S_REL_OUT;
                end
            end
            S_REL_OUT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_okind = OK_PAYLOAD;
                    n_obyte = ram_rdata;
                    n_ost   = ST_OK;
                    n_oexc  = 8'h00;
                    n_olen  = 6'd0;
                    n_olast = 1'b0;
                    n_ri    = r_ri + 6'd1;
                    n_state = S_REL;
                end
            end
            S_STAT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_okind = OK_STATUS;
                    n_obyte = 8'h00;
                    n_ost   = r_st;
                    n_oexc  = r_exc;
                    n_olen  = r_len;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_rsp.valid          = r_ov;
    assign o_rsp.out_kind       = r_okind;
    assign o_rsp.out_byte       = r_obyte;
    assign o_rsp.status         = r_ost;
    assign o_rsp.exception_code = r_oexc;
    assign o_rsp.data_length    = r_olen;
    assign o_rsp.last           = r_olast;

    `MRM_ASSERT(a_status_is_last, (o_rsp.valid && o_rsp.out_kind == OK_STATUS) |-> o_rsp.last, "status result without last")
    `MRM_ASSERT(a_body_within_cap, (r_phase == PH_RD_BODY) |-> (r_exp <= 6'(MAX_PAYLOAD)), "byte count above buffer limit")
    `MRM_ASSERT(a_release_in_range, (r_state == S_REL_OUT) |-> (r_ri < r_exp), "release index past byte count")
    `MRM_ASSERT_ALWAYS(a_reset_idle, $past(!i_rst_n) |-> (r_state == S_IDLE && !r_ov), "not idle after reset")

endmodule

>>> hdl/mrm_ram.sv
module mrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> tb/modbus_rtu_master_transaction_core_checker.sv
`timescale 1ns / 100ps

// Watches the request and response channels and the register port, predicts the
// response stream of the block and compares every accepted response with it.
module modbus_rtu_master_transaction_core_checker
    import mrm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    mrm_in_if          i_req,
    mrm_out_if         i_rsp,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [2:0] status;
        logic [7:0] exception_code;
        logic [5:0] data_length;
        logic       last;
    } t_rsp;

    t_rsp expected_rsp[$];

    // Predicted state of the transaction engine.
    logic [7:0]  slave_addr;
    logic [5:0]  capacity;
    t_phase      link_phase;
    logic [7:0]  req_function;
    logic [31:0] req_words;
    logic [15:0] rx_crc;
    logic [23:0] header;
    logic [6:0]  rx_count;
    logic [7:0]  body_len;
    logic [7:0]  rx_store [64];

    assign o_pending = expected_rsp.size();

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    task automatic emit(input logic [1:0] k, input logic [7:0] b, input logic [2:0] st,
                        input logic [7:0] exc, input logic [5:0] len, input logic lst);
        t_rsp r;
        r = '{k, b, st, exc, len, lst};
        expected_rsp.push_back(r);
    endtask

    task automatic conclude(input logic [2:0] st, input logic [7:0] exc, input logic [5:0] len);
        emit(OK_STATUS, 8'h00, st, exc, len, 1'b1);
        link_phase = PH_IDLE;
    endtask

    task automatic predict(input logic [1:0] kind, input logic use_ir, input logic [15:0] addr,
                           input logic [15:0] qv, input logic [7:0] rx);
        logic [7:0]  frame [8];
        logic [15:0] c;
        logic [7:0]  cap_eff;
        logic [31:0] echo;
        if (kind == KIND_READ || kind == KIND_WRITE) begin
            if (kind == KIND_READ && (qv == 0 || qv > MAX_QUANTITY)) begin
                conclude(ST_BAD_ARG, 8'h00, 6'd0);
                return;
            end
            req_function = (kind == KIND_WRITE) ? FN_WRITE_SINGLE :
                           (use_ir ? FN_READ_INPUT : FN_READ_HOLDING);
            req_words = {addr, qv};
            frame[0] = slave_addr;
            frame[1] = req_function;
            frame[2] = addr[15:8];
            frame[3] = addr[7:0];
            frame[4] = qv[15:8];
            frame[5] = qv[7:0];
            c = 16'hFFFF;
            for (int i = 0; i < 6; i++) c = crc_byte(c, frame[i]);
            frame[6] = c[7:0];
            frame[7] = c[15:8];
            for (int i = 0; i < 8; i++) emit(OK_TX, frame[i], ST_OK, 8'h00, 6'd0, i == 7);
            link_phase = (kind == KIND_WRITE) ? PH_WR_HDR : PH_RD_HDR;
            rx_crc = 16'hFFFF;
            header = '0;
            rx_count = '0;
            body_len = '0;
            return;
        end
        if (kind == KIND_TIMEOUT) begin
            if (link_phase != PH_IDLE)
                conclude((link_phase == PH_EXC_CRC) ? ST_INVALID : ST_TIMEOUT, 8'h00, 6'd0);
            return;
        end
        case (link_phase)
            PH_RD_HDR, PH_WR_HDR: begin
                header = {header[15:0], rx};
                rx_crc = crc_byte(rx_crc, rx);
                rx_count = rx_count + 1;
                if (rx_count < 3) return;
                rx_count = '0;
                cap_eff = (capacity > 6'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : {2'b00, capacity};
                if (header[23:16] != slave_addr) begin
                    conclude(ST_INVALID, 8'h00, 6'd0);
                end else if (header[15:8] == (req_function | FN_EXC_FLAG)) begin
                    link_phase = PH_EXC_CRC;
                end else if (header[15:8] != req_function) begin
                    conclude(ST_INVALID, 8'h00, 6'd0);
                end else if (link_phase == PH_WR_HDR) begin
                    link_phase = PH_WR_TAIL;
                end else if (header[7:0] > cap_eff || 32'(header[7:0]) + 2 > 64) begin
                    conclude(ST_TOO_LARGE, 8'h00, 6'd0);
                end else begin
                    body_len = header[7:0];
                    link_phase = PH_RD_BODY;
                end
            end
            PH_EXC_CRC: begin
                if (rx_count == 0) begin
                    rx_store[0] = rx;
                    rx_count = 1;
                end else if ({rx, rx_store[0]} != rx_crc) begin
                    conclude(ST_INVALID, 8'h00, 6'd0);
                end else begin
                    conclude(ST_EXCEPTION, header[7:0], 6'd0);
                end
            end
            PH_RD_BODY: begin
                if (rx_count < body_len) begin
                    rx_store[rx_count] = rx;
                    rx_crc = crc_byte(rx_crc, rx);
                    rx_count = rx_count + 1;
                end else if (rx_count == body_len) begin
                    rx_store[rx_count] = rx;
                    rx_count = rx_count + 1;
                end else if ({rx, rx_store[body_len]} != rx_crc) begin
                    conclude(ST_INVALID, 8'h00, 6'd0);
                end else begin
                    for (int i = 0; i < body_len; i++)
                        emit(OK_PAYLOAD, rx_store[i], ST_OK, 8'h00, 6'd0, 1'b0);
                    conclude(ST_OK, 8'h00, body_len[5:0]);
                end
            end
            PH_WR_TAIL: begin
                if (rx_count < 3) rx_crc = crc_byte(rx_crc, rx);
                if (rx_count < 4) begin
                    rx_store[rx_count] = rx;
                    rx_count = rx_count + 1;
                end else begin
                    echo = {header[7:0], rx_store[0], rx_store[1], rx_store[2]};
                    if ({rx, rx_store[3]} != rx_crc || echo != req_words)
                        conclude(ST_INVALID, 8'h00, 6'd0);
                    else
                        conclude(ST_OK, 8'h00, 6'd0);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (!i_rst_n) begin
            slave_addr = 8'd254;
            capacity = 6'd8;
            link_phase = PH_IDLE;
            req_function = '0;
            req_words = '0;
            rx_crc = 16'hFFFF;
            header = '0;
            rx_count = '0;
            body_len = '0;
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SLAVE_ADDRESS) slave_addr = i_cfg_data;
                else capacity = i_cfg_data[5:0];
            end
            if (i_req.valid && i_req.ready)
                predict(i_req.kind, i_req.use_input_regs, i_req.reg_address,
                        i_req.quantity_or_value, i_req.rx_byte);
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.out_kind, i_rsp.out_byte, i_rsp.status, i_rsp.exception_code,
                        i_rsp.data_length, i_rsp.last};
                if (expected_rsp.size() == 0) begin
                    $display("%0t: unexpected response, actual %h", $time, got);
                    o_fail_count++;
                end else begin
                    want = expected_rsp.pop_front();
                    if (got !== want) begin
                        $display({"%0t: response mismatch, expected kind %0d byte %h st %0d ",
                                  "exc %h len %0d last %0d, actual kind %0d byte %h st %0d ",
                                  "exc %h len %0d last %0d"},
                                 $time, want.out_kind, want.out_byte, want.status,
                                 want.exception_code, want.data_length, want.last,
                                 got.out_kind, got.out_byte, got.status,
                                 got.exception_code, got.data_length, got.last);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/modbus_rtu_master_transaction_core_tb.sv
`timescale 1ns / 100ps

// Top level of the testbench. It drives requests and reply frames into the block, holds
// the response channel back at random, and leaves all prediction and comparison to the
// checker, which it asks only for the number of failures and outstanding responses.
module modbus_rtu_master_transaction_core_tb;
    import mrm_pkg::*;

    // The ways in which a reply frame from the slave is shaped.
    typedef enum int {
        R_GOOD, R_BAD_CRC, R_BAD_ECHO, R_WRONG_ADDR, R_WRONG_FN, R_TOO_LARGE,
        R_TIMEOUT, R_ABANDON
    } t_reply;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;
    int         fail_count;
    int         pending;
    int         items;
    int         stall_left;
    bit         calm;       // when set, neither side idles
    logic [7:0] cur_addr;
    logic [5:0] cur_cap;
    logic [7:0] reply_q[$];

    mrm_in_if  req ();
    mrm_out_if rsp ();

    modbus_rtu_master_transaction_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req.sink),
        .o_rsp      (rsp.source)
    );

    modbus_rtu_master_transaction_core_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req        (req),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A generous upper bound: even every item waiting out long stalls stays far below it.
    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // Mostly back-to-back or short gaps, with the occasional long one.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // The response side stalls independently of the request side.
    always @(posedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
        end else begin
            g = pick_gap();
            rsp.ready <= (g == 0);
            stall_left = (g > 0) ? g - 1 : 0;
        end
    end

    // Frame check sequence over a reply being built, so that good replies can be made.
    function automatic logic [15:0] frame_crc(input logic [7:0] q[$]);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (q[i]) begin
            c = c ^ {8'h00, q[i]};
            for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    // One transfer on the request channel. Valid is lowered only when a gap follows,
    // so it is never lowered and raised again at the same edge.
    task automatic push_item(input logic [1:0] k, input logic use_ir, input logic [15:0] a,
                             input logic [15:0] qv, input logic [7:0] rx);
        int g;
        g = pick_gap();
        if (g > 0) begin
            req.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.kind <= k;
        req.use_input_regs <= use_ir;
        req.reg_address <= a;
        req.quantity_or_value <= qv;
        req.rx_byte <= rx;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        items++;
    endtask

    // Received bytes carry random content in the fields that do not matter to them.
    task automatic push_byte(input logic [7:0] b);
        push_item(KIND_RXBYTE, 1'($urandom), 16'($urandom), 16'($urandom), b);
    endtask

    task automatic push_timeout();
        push_item(KIND_TIMEOUT, 1'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // Waits until every predicted response has arrived, then for the longest tail of the
    // block, so that no request or reply byte is still being worked on.
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [7:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SLAVE_ADDRESS) cur_addr = data;
        else cur_cap = data[5:0];
    endtask

    // A timeout first forces the block to idle, then both registers get new settings.
    task automatic reconfigure(input logic [7:0] addr, input logic [5:0] cap);
        push_timeout();
        drain();
        cfg_write(CFG_SLAVE_ADDRESS, addr);
        cfg_write(CFG_CAPACITY, {2'b00, cap});
    endtask

    // One request followed by a reply shaped as asked. A count below zero lets the
    // reply carry the register count in bytes, clipped to the capacity.
    task automatic transaction(input bit is_read, input logic use_ir, input logic [15:0] ra,
                               input logic [15:0] qv, input t_reply shape, input bit as_exc,
                               input int count);
        logic [7:0]  fn;
        logic [15:0] c;
        int          cap_eff;
        int          n;
        int          cut;
        fn = !is_read ? FN_WRITE_SINGLE : (use_ir ? FN_READ_INPUT : FN_READ_HOLDING);
        push_item(is_read ? KIND_READ : KIND_WRITE, use_ir, ra, qv, 8'($urandom));
        reply_q = {};
        reply_q.push_back(shape == R_WRONG_ADDR ? cur_addr ^ 8'($urandom_range(1, 255))
                                                : cur_addr);
        if (shape == R_WRONG_FN) begin
            do fn = 8'($urandom); while (fn == reply_q[0] || fn == FN_READ_HOLDING ||
                                         fn == FN_READ_INPUT || fn == FN_WRITE_SINGLE ||
                                         fn[6:0] == FN_READ_HOLDING ||
                                         fn[6:0] == FN_READ_INPUT ||
                                         fn[6:0] == FN_WRITE_SINGLE);
            reply_q.push_back(fn);
        end else begin
            reply_q.push_back(as_exc ? (fn | FN_EXC_FLAG) : fn);
        end
        cap_eff = (cur_cap > MAX_PAYLOAD) ? MAX_PAYLOAD : cur_cap;
        if (as_exc) begin
            reply_q.push_back(8'($urandom));
        end else if (is_read) begin
            if (shape == R_TOO_LARGE) n = $urandom_range(cap_eff + 1, 255);
            else if (count >= 0) n = count;
            else if ($urandom_range(0, 3) == 0) n = $urandom_range(0, cap_eff);
            else n = (2 * qv > cap_eff) ? cap_eff : 2 * qv;
            reply_q.push_back(8'(n));
            if (shape != R_TOO_LARGE)
                repeat (n) reply_q.push_back(8'($urandom));
        end else begin
            reply_q.push_back(ra[15:8]);
            reply_q.push_back(ra[7:0]);
            reply_q.push_back(qv[15:8]);
            reply_q.push_back(qv[7:0]);
            if (shape == R_BAD_ECHO)
                reply_q[$urandom_range(2, 5)] ^= 8'(1 << $urandom_range(0, 7));
        end
        c = frame_crc(reply_q);
        reply_q.push_back(c[7:0]);
        reply_q.push_back(c[15:8]);
        if (shape == R_BAD_CRC)
            reply_q[reply_q.size() - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        // Frames refused at the header end after three bytes.
        if (shape inside {R_WRONG_ADDR, R_WRONG_FN, R_TOO_LARGE}) cut = 3;
        else if (shape inside {R_TIMEOUT, R_ABANDON}) cut = $urandom_range(0, reply_q.size() - 1);
        else cut = reply_q.size();
        for (int i = 0; i < cut; i++) push_byte(reply_q[i]);
        if (shape == R_TIMEOUT) push_timeout();
    endtask

    task automatic random_transaction();
        int     r;
        t_reply shape;
        bit     is_read;
        r = $urandom_range(0, 99);
        is_read = $urandom_range(0, 2) != 0;
        if (r < 45) shape = R_GOOD;
        else if (r < 55) shape = R_BAD_CRC;
        else if (r < 62) shape = is_read ? R_TOO_LARGE : R_BAD_ECHO;
        else if (r < 70) shape = R_WRONG_ADDR;
        else if (r < 78) shape = R_WRONG_FN;
        else if (r < 92) shape = R_TIMEOUT;
        else shape = R_ABANDON;
        transaction(is_read, 1'($urandom), 16'($urandom),
                    is_read ? 16'($urandom_range(1, MAX_QUANTITY)) : 16'($urandom),
                    shape, (shape != R_TOO_LARGE && shape != R_WRONG_FN &&
                            $urandom_range(0, 4) == 0), -1);
    endtask

    initial begin
        int start;
        req.valid <= 1'b0;
        req.kind <= KIND_TIMEOUT;
        req.use_input_regs <= 1'b0;
        req.reg_address <= '0;
        req.quantity_or_value <= '0;
        req.rx_byte <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_SLAVE_ADDRESS;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;
        items = 0;
        calm = 1'b0;
        cur_addr = 8'd254;
        cur_cap = 6'd8;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, under the reset settings. Events that arrive while nothing is
        // pending are ignored, and refused register counts end at once.
        push_timeout();
        push_byte(8'hA5);
        push_item(KIND_READ, 1'b0, 16'h0000, 16'd0, 8'h00);
        push_item(KIND_READ, 1'b1, 16'hFFFF, 16'd7, 8'hFF);
        push_item(KIND_READ, 1'b0, 16'h1234, 16'hFFFF, 8'h00);
        transaction(1'b1, 1'b0, 16'h0000, 16'd4, R_GOOD, 1'b0, 8);
        transaction(1'b1, 1'b1, 16'hFFFF, 16'd1, R_GOOD, 1'b0, 0);
        transaction(1'b0, 1'b0, 16'hFFFF, 16'hFFFF, R_GOOD, 1'b0, -1);
        transaction(1'b0, 1'b1, 16'h0000, 16'h0000, R_BAD_ECHO, 1'b0, -1);
        transaction(1'b1, 1'b0, 16'h00FF, 16'd6, R_GOOD, 1'b1, -1);
        // A timeout while the exception checksum is awaited counts as a bad reply.
        transaction(1'b1, 1'b0, 16'hFF00, 16'd2, R_ABANDON, 1'b1, -1);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_timeout();
        transaction(1'b1, 1'b1, 16'h5A5A, 16'd3, R_TOO_LARGE, 1'b0, -1);
        transaction(1'b0, 1'b0, 16'hA5A5, 16'h5A5A, R_WRONG_ADDR, 1'b0, -1);

        // Extremes of both registers; the full-size read runs under a capacity above the
        // buffer limit, which must act as the limit itself.
        reconfigure(8'd0, 6'd62);
        transaction(1'b1, 1'b0, 16'h0001, 16'd6, R_GOOD, 1'b0, 12);
        reconfigure(8'd255, 6'd63);
        transaction(1'b1, 1'b1, 16'h8000, 16'd6, R_TOO_LARGE, 1'b0, -1);
        transaction(1'b1, 1'b0, 16'h8000, 16'd6, R_GOOD, 1'b0, 62);
        reconfigure(8'd17, 6'd2);
        transaction(1'b1, 1'b0, 16'h7FFF, 16'd1, R_GOOD, 1'b0, 2);

        // Random part: mostly complete transactions with random content, some noise,
        // calm stretches without any idling and occasional changes of settings.
        start = items;
        while (items - start < 50) begin
            if ($urandom_range(0, 7) == 0) calm = !calm;
            if ($urandom_range(0, 24) == 0) begin
                case ($urandom_range(0, 3))
                    0: reconfigure(8'($urandom), 6'(MAX_PAYLOAD));
                    1: reconfigure(8'($urandom), 6'd2);
                    default: reconfigure(8'($urandom), 6'($urandom_range(2, 12)));
                endcase
            end else if ($urandom_range(0, 9) == 0) begin
                push_item(2'($urandom), 1'($urandom), 16'($urandom),
                          ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 8))
                                                      : 16'($urandom), 8'($urandom));
            end else begin
                random_transaction();
            end
        end
        calm = 1'b0;
        drain();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/mrm_pkg.sv
hdl/mrm_in_if.sv
hdl/mrm_out_if.sv
hdl/mrm_ram.sv
hdl/modbus_rtu_master_transaction_core.sv
tb/modbus_rtu_master_transaction_core_checker.sv
tb/modbus_rtu_master_transaction_core_tb.sv
